### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### design/ddmw_pkg.sv
// ----------------------------------------------------------------------------
// ddmw_pkg
// Types and constants shared by the drive mixer and watchdog modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddmw_pkg;

  // Raw command bytes are centered on this value; one unit is 1/127.
  localparam int CMD_CENTER = 127;
  localparam int UNIT_SCALE = 127;
  localparam int DUTY_MAX   = 255;

  localparam logic [15:0] CNT_MAX       = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] BLINK_RESET   = 16'd1000;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_BLINK   = 1'b1;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_t;

  typedef struct packed {
    logic       link_up;
    logic       has_command;
    logic [7:0] speed_byte;
    logic [7:0] steer_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] left_dir;
    logic [7:0] left_duty;
    logic [1:0] right_dir;
    logic [7:0] right_duty;
    logic       led_on;
    logic       is_linked;
  } drv_item_t;

  // Bridge settings for both motors.
  typedef struct packed {
    logic [1:0] left_dir;
    logic [7:0] left_duty;
    logic [1:0] right_dir;
    logic [7:0] right_duty;
  } drive_t;

  localparam drive_t DRIVE_STOP = '{
    left_dir:   DIR_OFF,
    left_duty:  8'd0,
    right_dir:  DIR_OFF,
    right_duty: 8'd0
  };

endpackage

`default_nettype wire

### design/ddmw_cfg.sv
// ----------------------------------------------------------------------------
// ddmw_cfg
// APB register file holding the timeout and blink periods.
// ----------------------------------------------------------------------------
`default_nettype none

module ddmw_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ddmw_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ddmw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ddmw_pkg::APB_DATA_W-1:0]     prdata,
  output logic      [15:0]                         timeout_ticks,
  output logic      [15:0]                         blink_ticks
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= ddmw_pkg::TIMEOUT_RESET;
      blink_ticks   <= ddmw_pkg::BLINK_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ddmw_pkg::REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        ddmw_pkg::REG_BLINK:   blink_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ddmw_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      ddmw_pkg::REG_BLINK:   prdata = {16'd0, blink_ticks};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/ddmw_mixer.sv
// ----------------------------------------------------------------------------
// ddmw_mixer
// Mixes speed and steer bytes into left and right direction and duty.
// ----------------------------------------------------------------------------
`default_nettype none

module ddmw_mixer (
  input  wire logic [7:0]       speed_byte,
  input  wire logic [7:0]       steer_byte,
  output ddmw_pkg::drive_t      drive
);

  // Ten signed bits cover every intermediate from -255 to +256.
  logic signed [9:0] s;
  logic signed [9:0] a;
  logic signed [9:0] mag;
  logic signed [9:0] sum;
  logic signed [9:0] dif;
  logic signed [9:0] l;
  logic signed [9:0] r;

  function automatic logic signed [9:0] clamp_fwd(input logic signed [9:0] v);
    logic signed [9:0] hi;
    hi = $signed(10'(ddmw_pkg::UNIT_SCALE));
    if (v < 10'sd0) return 10'sd0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [9:0] clamp_rev(input logic signed [9:0] v);
    logic signed [9:0] lo;
    lo = -$signed(10'(ddmw_pkg::UNIT_SCALE));
    if (v < lo) return lo;
    if (v > 10'sd0) return 10'sd0;
    return v;
  endfunction

  function automatic logic [1:0] dir_of(input logic signed [9:0] v);
    if (v > 10'sd0) return ddmw_pkg::DIR_FWD;
    if (v < 10'sd0) return ddmw_pkg::DIR_REV;
    return ddmw_pkg::DIR_OFF;
  endfunction

  // floor(m * 255 / 127) is 2m + floor(m / 127); with m at most 128 that is
  // 2m below full scale and saturates to the maximum duty at or above it.
  function automatic logic [7:0] duty_of(input logic signed [9:0] v);
    logic [9:0] m;
    m = (v < 10'sd0) ? 10'(-v) : 10'(v);
    if (m >= 10'(ddmw_pkg::UNIT_SCALE)) return 8'(ddmw_pkg::DUTY_MAX);
    return {m[6:0], 1'b0};
  endfunction

  always_comb begin
    s   = $signed({2'b00, speed_byte}) - $signed(10'(ddmw_pkg::CMD_CENTER));
    a   = $signed({2'b00, steer_byte}) - $signed(10'(ddmw_pkg::CMD_CENTER));
    mag = (a < 10'sd0) ? -a : a;
    sum = s + mag;
    dif = s - mag;
    l   = s;
    r   = s;
    priority if (s == 10'sd0) begin
      // Pivot in place toward the steer side.
      if (a > 10'sd0) begin
        l = a;
        r = 10'sd0;
      end else if (a < 10'sd0) begin
        l = 10'sd0;
        r = -a;
      end
    end else if (s > 10'sd0) begin
      if (a > 10'sd0) begin
        r = clamp_fwd(dif);
        l = clamp_fwd(sum);
      end else if (a < 10'sd0) begin
        l = clamp_fwd(dif);
        r = clamp_fwd(sum);
      end
    end else begin
      if (a > 10'sd0) begin
        r = clamp_rev(sum);
        l = clamp_rev(dif);
      end else if (a < 10'sd0) begin
        l = clamp_rev(sum);
        r = clamp_rev(dif);
      end
    end
    drive.left_dir   = dir_of(l);
    drive.left_duty  = duty_of(l);
    drive.right_dir  = dir_of(r);
    drive.right_duty = duty_of(r);
  end

endmodule

`default_nettype wire

### design/ddmw_watchdog.sv
// ----------------------------------------------------------------------------
// ddmw_watchdog
// Link and data watchdog state; produces the result for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ddmw_watchdog (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire ddmw_pkg::cmd_item_t    cmd,
  input  wire logic [15:0]            timeout_ticks,
  input  wire logic [15:0]            blink_ticks,
  output ddmw_pkg::drv_item_t         result
);

  ddmw_pkg::drive_t drive;
  ddmw_pkg::drive_t drive_next;
  ddmw_pkg::drive_t mixed;
  logic             linked;
  logic             linked_next;
  logic             led_level;
  logic             led_level_next;
  logic             blink_phase;
  logic             blink_phase_next;
  logic [15:0]      ticks_since_data;
  logic [15:0]      ticks_since_data_next;
  logic [15:0]      ticks_since_blink;
  logic [15:0]      ticks_since_blink_next;

  ddmw_mixer u_mixer (
    .speed_byte (cmd.speed_byte),
    .steer_byte (cmd.steer_byte),
    .drive      (mixed)
  );

  always_comb begin
    drive_next       = drive;
    linked_next      = linked;
    led_level_next   = led_level;
    blink_phase_next = blink_phase;
    ticks_since_data_next = (ticks_since_data == ddmw_pkg::CNT_MAX) ?
                            ticks_since_data : ticks_since_data + 16'd1;
    ticks_since_blink_next = (ticks_since_blink == ddmw_pkg::CNT_MAX) ?
                             ticks_since_blink : ticks_since_blink + 16'd1;

    if (!cmd.link_up) begin
      if (linked) begin
        drive_next     = ddmw_pkg::DRIVE_STOP;
        linked_next    = 1'b0;
        led_level_next = 1'b0;
      end
      if (ticks_since_blink_next >= blink_ticks) begin
        ticks_since_blink_next = 16'd0;
        blink_phase_next       = !blink_phase;
        led_level_next         = !blink_phase;
      end
    end

    if (cmd.has_command) begin
      if (!linked_next) begin
        linked_next    = 1'b1;
        led_level_next = 1'b1;
      end
      drive_next            = mixed;
      ticks_since_data_next = 16'd0;
    end

    if (linked_next && (ticks_since_data_next >= timeout_ticks)) begin
      drive_next     = ddmw_pkg::DRIVE_STOP;
      linked_next    = 1'b0;
      led_level_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive             <= ddmw_pkg::DRIVE_STOP;
      linked            <= 1'b0;
      led_level         <= 1'b0;
      blink_phase       <= 1'b0;
      ticks_since_data  <= 16'd0;
      ticks_since_blink <= 16'd0;
    end else if (step) begin
      drive             <= drive_next;
      linked            <= linked_next;
      led_level         <= led_level_next;
      blink_phase       <= blink_phase_next;
      ticks_since_data  <= ticks_since_data_next;
      ticks_since_blink <= ticks_since_blink_next;
    end
  end

  assign result.left_dir   = drive_next.left_dir;
  assign result.left_duty  = drive_next.left_duty;
  assign result.right_dir  = drive_next.right_dir;
  assign result.right_duty = drive_next.right_duty;
  assign result.led_on     = led_level_next;
  assign result.is_linked  = linked_next;

endmodule

`default_nettype wire

### design/differential_drive_mixer_watchdog.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_watchdog
// Each command is captured in the input register, and its result in the result register.
// Throughput: one transaction per cycle while drv_stall is low, set by the input and result registers.
// Reset: synchronous rst stops both motors, clears link, LED and counters, and
// loads 1000 into both period registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

// Data path overview.
//
// Each command transaction is one millisecond tick. It is first captured in
// an input register. From there the watchdog and mixer logic work out the
// whole tick in one pass: counter updates, link-loss handling, LED blinking,
// mixing of a new speed/steer pair, and the data timeout. The result is
// written into the result register in the same edge that commits the new
// watchdog state, so state and delivered results always move together.
//
// The input register moves forward whenever the result register is empty or
// its transaction is being taken, so the block keeps accepting a transaction
// every cycle while results drain. The stall towards the command side only
// rises when both registers are full and the result side is stalling.

module differential_drive_mixer_watchdog (
  input  wire logic                                clk,
  input  wire logic                                rst,

  // Command channel (one tick per transaction).
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire ddmw_pkg::cmd_item_t                 cmd,

  // Drive result channel (one result per tick).
  output logic                                     drv_valid,
  input  wire logic                                drv_stall,
  output ddmw_pkg::drv_item_t                      drv,

  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ddmw_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ddmw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ddmw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  logic                 s1_valid;
  ddmw_pkg::cmd_item_t  s1_cmd;
  logic                 s2_ready;
  logic                 s1_adv;
  logic                 cmd_take;
  ddmw_pkg::drv_item_t  result;
  logic [15:0]          timeout_ticks;
  logic [15:0]          blink_ticks;

  // Registers are always ready; a write lands on the access-phase edge.
  assign pready = 1'b1;

  ddmw_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .timeout_ticks (timeout_ticks),
    .blink_ticks   (blink_ticks)
  );

  // The result register can take a new transaction when it is empty or
  // when its current one leaves at this edge.
  assign s2_ready  = !drv_valid || !drv_stall;
  assign s1_adv    = s1_valid && s2_ready;
  assign cmd_stall = s1_valid && !s2_ready;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_cmd <= cmd;
    end
  end

  // The watchdog state commits exactly when its tick moves into the result
  // register, so one accepted transaction is one step of the state.
  ddmw_watchdog u_watchdog (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_adv),
    .cmd           (s1_cmd),
    .timeout_ticks (timeout_ticks),
    .blink_ticks   (blink_ticks),
    .result        (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (s1_adv) begin
      drv_valid <= 1'b1;
    end else if (!drv_stall) begin
      drv_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drv <= result;
    end
  end

  // An empty input register never pushes back on the command side.
  `ASSERT_IMPL(a_no_stall_when_empty, clk, rst, !s1_valid, !cmd_stall,
               "command stalled with an empty input register")

  // A tick that leaves the input register always shows up as a result.
  `ASSERT_NEXT(a_step_gives_result, clk, rst, s1_adv, drv_valid,
               "advanced tick produced no result")

  // The motors only run while the link is marked connected.
  `ASSERT_IMPL(a_drive_needs_link, clk, rst, drv_valid && !drv.is_linked,
               (drv.left_dir == ddmw_pkg::DIR_OFF) &&
               (drv.right_dir == ddmw_pkg::DIR_OFF),
               "motor driven while not linked")

  // A bridge is off exactly when its duty is zero.
  `ASSERT_IMPL(a_left_dir_duty, clk, rst, drv_valid,
               (drv.left_dir == ddmw_pkg::DIR_OFF) == (drv.left_duty == 8'd0),
               "left direction and duty disagree")
  `ASSERT_IMPL(a_right_dir_duty, clk, rst, drv_valid,
               (drv.right_dir == ddmw_pkg::DIR_OFF) == (drv.right_duty == 8'd0),
               "right direction and duty disagree")

endmodule

`default_nettype wire

### dv/ddmw_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddmw_drive_checker
// Watches the command, drive and register ports of the drive mixer, keeps its
// own model of the watchdog and mixer, and compares every drive result.
// ----------------------------------------------------------------------------
module ddmw_drive_checker
  import ddmw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_item_t             cmd,
  input  logic                  drv_valid,
  input  logic                  drv_stall,
  input  drv_item_t             drv,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  // Model copy of the registers and the watchdog state.
  logic [15:0] timeout_reg;
  logic [15:0] blink_reg;
  logic [15:0] data_age;
  logic [15:0] blink_age;
  logic        linked;
  logic        led_level;
  logic        blink_phase;
  drive_t      motors;

  drv_item_t   drive_expected_q[$];
  int          err_cnt = 0;
  int          check_cnt = 0;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic dir_t dir_of(int v);
    if (v > 0) return DIR_FWD;
    if (v < 0) return DIR_REV;
    return DIR_OFF;
  endfunction

  function automatic logic [7:0] duty_of(int v);
    int m;
    m = (v < 0) ? -v : v;
    m = (m * DUTY_MAX) / UNIT_SCALE;
    return (m > DUTY_MAX) ? 8'(DUTY_MAX) : 8'(m);
  endfunction

  // Mixes one speed/steer pair into left and right drive values.
  function automatic drive_t mix_drive(logic [7:0] speed, logic [7:0] steer);
    int     s;
    int     a;
    int     mag;
    int     l;
    int     r;
    drive_t d;
    s   = int'(speed) - CMD_CENTER;
    a   = int'(steer) - CMD_CENTER;
    mag = (a < 0) ? -a : a;
    l   = s;
    r   = s;
    if (s == 0) begin
      if (a > 0) begin
        l = a;
        r = 0;
      end else if (a < 0) begin
        l = 0;
        r = -a;
      end
    end else if (s > 0) begin
      if (a > 0) begin
        r = clip(s - mag, 0, UNIT_SCALE);
        l = clip(s + mag, 0, UNIT_SCALE);
      end else if (a < 0) begin
        l = clip(s - mag, 0, UNIT_SCALE);
        r = clip(s + mag, 0, UNIT_SCALE);
      end
    end else begin
      if (a > 0) begin
        r = clip(s + mag, -UNIT_SCALE, 0);
        l = clip(s - mag, -UNIT_SCALE, 0);
      end else if (a < 0) begin
        l = clip(s + mag, -UNIT_SCALE, 0);
        r = clip(s - mag, -UNIT_SCALE, 0);
      end
    end
    d.left_dir   = dir_of(l);
    d.left_duty  = duty_of(l);
    d.right_dir  = dir_of(r);
    d.right_duty = duty_of(r);
    return d;
  endfunction

  // Advances the model by one tick and returns the drive result it gives.
  function automatic drv_item_t advance_tick(cmd_item_t c);
    data_age  = (data_age == CNT_MAX) ? data_age : data_age + 16'd1;
    blink_age = (blink_age == CNT_MAX) ? blink_age : blink_age + 16'd1;
    if (!c.link_up) begin
      if (linked) begin
        motors    = DRIVE_STOP;
        linked    = 1'b0;
        led_level = 1'b0;
      end
      if (blink_age >= blink_reg) begin
        blink_age   = '0;
        blink_phase = ~blink_phase;
        led_level   = blink_phase;
      end
    end
    if (c.has_command) begin
      if (!linked) begin
        linked    = 1'b1;
        led_level = 1'b1;
      end
      motors   = mix_drive(c.speed_byte, c.steer_byte);
      data_age = '0;
    end
    if (linked && data_age >= timeout_reg) begin
      motors    = DRIVE_STOP;
      linked    = 1'b0;
      led_level = 1'b0;
    end
    // The drive fields lead the result struct, LED and link flag follow.
    return {motors, led_level, linked};
  endfunction

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    drv_item_t want;
    if (rst) begin
      timeout_reg = TIMEOUT_RESET;
      blink_reg   = BLINK_RESET;
      data_age    = '0;
      blink_age   = '0;
      linked      = 1'b0;
      led_level   = 1'b0;
      blink_phase = 1'b0;
      motors      = DRIVE_STOP;
      drive_expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TIMEOUT) timeout_reg = pwdata[15:0];
        else blink_reg = pwdata[15:0];
      end
      if (drv_valid && !drv_stall) begin
        if (drive_expected_q.size() == 0) begin
          $error("drive result arrived with no command tick pending");
          err_cnt++;
        end else begin
          want = drive_expected_q.pop_front();
          check_field("left_dir", want.left_dir, drv.left_dir);
          check_field("left_duty", want.left_duty, drv.left_duty);
          check_field("right_dir", want.right_dir, drv.right_dir);
          check_field("right_duty", want.right_duty, drv.right_duty);
          check_field("led_on", want.led_on, drv.led_on);
          check_field("is_linked", want.is_linked, drv.is_linked);
          check_cnt++;
        end
      end
      if (cmd_valid && !cmd_stall) drive_expected_q.push_back(advance_tick(cmd));
    end
    errors  <= err_cnt;
    pending <= drive_expected_q.size();
    checked <= check_cnt;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives millisecond ticks and register writes into the drive mixer with
// watchdog; a separate checker predicts and compares every drive result.
// ----------------------------------------------------------------------------
module tb;
  import ddmw_pkg::*;

  // Cycles without any transaction before the run is declared hung. The
  // longest legal quiet stretch is the receiver's long hold-off.
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 64;
  localparam int NUM_SETTINGS = 7;

  logic                  clk;
  logic                  rst = 1'b1;

  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_item_t             cmd = '0;

  logic                  drv_valid;
  logic                  drv_stall = 1'b0;
  drv_item_t             drv;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    errors;
  int                    pending;
  int                    checked;

  // Idling controls for the sender and the receiver.
  bit                    tx_calm = 1'b0;
  bit                    rx_calm = 1'b0;
  bit                    hold_req = 1'b0;

  int                    ticks_sent = 0;
  int                    settings_used = 0;
  int                    idle_cycles = 0;

  differential_drive_mixer_watchdog uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .drv_valid (drv_valid),
    .drv_stall (drv_stall),
    .drv       (drv),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ddmw_drive_checker drive_chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .drv_valid (drv_valid),
    .drv_stall (drv_stall),
    .drv       (drv),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang detection: any command, drive or register transaction counts as
  // progress. Reaching the limit means the block stopped moving.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (drv_valid && !drv_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive result receiver. Before taking each result it stalls for a random
  // number of cycles, none in calm stretches, and once on request for a long
  // hold-off so that both internal registers fill and the command side stalls.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        drv_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      drv_stall <= 1'b0;
      do @(posedge clk); while (!(drv_valid && !drv_stall));
    end
  end

  // Offers one tick after a random gap and holds it until it is taken. Valid
  // only drops when a gap is drawn, so back-to-back ticks keep it high.
  task automatic send_tick(input cmd_item_t item);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= item;
    do @(posedge clk); while (cmd_stall);
    ticks_sent++;
  endtask

  // Stops offering ticks until every predicted result has been compared,
  // then lets the two-stage pipeline settle.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then an access cycle; the write lands once pready is seen.
  task automatic write_reg(input logic which, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register writes only happen with the block idle, and the bus returns to
  // idle between the two writes.
  task automatic apply_setting(input logic [15:0] timeout, input logic [15:0] blink);
    wait_drained();
    write_reg(REG_TIMEOUT, timeout);
    @(posedge clk);
    write_reg(REG_BLINK, blink);
    settings_used++;
  endtask

  // Command bytes lean toward the corners of the mixing law: full reverse,
  // stop and its neighbors, and the 255 byte that overshoots full scale.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd126;
      3:       return 8'd127;
      4:       return 8'd128;
      5:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic cmd_item_t rand_tick(input int link_pct, input int cmd_pct);
    cmd_item_t t;
    t.link_up     = ($urandom_range(0, 99) < link_pct);
    t.has_command = ($urandom_range(0, 99) < cmd_pct);
    t.speed_byte  = pick_byte();
    t.steer_byte  = pick_byte();
    return t;
  endfunction

  // Random traffic built from short segments, each with its own character:
  // steady driving, quiet stretches that let the data timeout expire, link
  // outages that exercise the blink logic, reconnect churn, and plain noise.
  task automatic run_random(input int n_items);
    int left;
    int seg_len;
    int link_pct;
    int cmd_pct;
    left = n_items;
    while (left > 0) begin
      seg_len = $urandom_range(5, 20);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          link_pct = 95;
          cmd_pct  = 50;
        end
        4, 5: begin
          link_pct = 100;
          cmd_pct  = 3;
        end
        6, 7: begin
          link_pct = 10;
          cmd_pct  = 15;
        end
        8: begin
          link_pct = 50;
          cmd_pct  = 50;
        end
        default: begin
          link_pct = 60;
          cmd_pct  = 60;
        end
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      repeat (seg_len) send_tick(rand_tick(link_pct, cmd_pct));
      left -= seg_len;
      // Now and then the sender pauses until the pipeline is empty.
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [15:0] timeout_set [NUM_SETTINGS];
    logic [15:0] blink_set   [NUM_SETTINGS];

    // Zero registers make the timeout fire in the command's own tick and the
    // LED toggle on every link-down tick; the others span one tick to full
    // scale.
    timeout_set = '{16'd0, 16'd1, 16'd7, 16'd40, 16'hFFFF, 16'd300, 16'd2};
    blink_set   = '{16'd0, 16'd1, 16'd3, 16'd12, 16'd5, 16'hFFFF, 16'd1};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset register values. Each tick is packed as
    // link_up, has_command, speed byte, steer byte.
    send_tick({1'b1, 1'b0, 8'd127, 8'd127}); // idle tick, still unlinked
    send_tick({1'b1, 1'b1, 8'd127, 8'd127}); // stop command connects
    send_tick({1'b1, 1'b1, 8'd255, 8'd255}); // full forward, hard right
    send_tick({1'b1, 1'b1, 8'd0, 8'd0});     // full reverse, hard left
    send_tick({1'b1, 1'b1, 8'd255, 8'd127}); // overshoot, duty saturates
    send_tick({1'b1, 1'b1, 8'd0, 8'd127});   // straight full reverse
    send_tick({1'b1, 1'b1, 8'd127, 8'd255}); // pivot right past full scale
    send_tick({1'b1, 1'b1, 8'd127, 8'd0});   // pivot left
    send_tick({1'b1, 1'b1, 8'd127, 8'd126}); // smallest pivot
    send_tick({1'b1, 1'b1, 8'd200, 8'd160}); // forward, steer inside range
    send_tick({1'b1, 1'b1, 8'd250, 8'd140}); // forward, outer side clamps
    send_tick({1'b1, 1'b1, 8'd10, 8'd100});  // reverse, outer side clamps
    send_tick({1'b1, 1'b1, 8'd40, 8'd200});  // reverse, steering right
    send_tick({1'b1, 1'b1, 8'd128, 8'd126}); // creep forward, slight left
    send_tick({1'b1, 1'b1, 8'd126, 8'd128}); // creep reverse, slight right
    send_tick({1'b1, 1'b1, 8'd255, 8'd0});   // forward with full left steer
    send_tick({1'b1, 1'b1, 8'd0, 8'd255});   // reverse with full right steer
    send_tick({1'b0, 1'b0, 8'd127, 8'd127}); // link loss stops the motors
    send_tick({1'b0, 1'b1, 8'd180, 8'd90});  // command taken while link is down
    send_tick({1'b0, 1'b0, 8'd127, 8'd127}); // stop lands on the next down tick
    send_tick({1'b1, 1'b0, 8'd127, 8'd127});
    send_tick({1'b1, 1'b1, 8'hAA, 8'h55});
    send_tick({1'b1, 1'b1, 8'h55, 8'hAA});

    // Random traffic under each register setting. The third setting opens
    // with a calm burst while the receiver holds off for a long stretch.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      apply_setting(timeout_set[p], blink_set[p]);
      if (p == 2) begin
        tx_calm  = 1'b1;
        rx_calm  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_tick(rand_tick(95, 50));
      end
      run_random(80);
    end

    // Closing ticks under the last setting: link-down ticks, a command taken
    // while the link is down, and the stop on the next link-down tick.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (3) send_tick({1'b0, 1'b0, 8'd127, 8'd127});
    send_tick({1'b0, 1'b1, 8'd60, 8'd210});
    send_tick({1'b0, 1'b0, 8'd127, 8'd127});

    wait_drained();

    $display("Summary: %0d ticks sent, %0d drive results compared, %0d register settings.",
             ticks_sent, checked, settings_used);
    $display("Summary: mixing corners, link loss and blink, timeouts, stalls, drains.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/ddmw_pkg.sv
design/ddmw_cfg.sv
design/ddmw_mixer.sv
design/ddmw_watchdog.sv
design/differential_drive_mixer_watchdog.sv
dv/ddmw_drive_checker.sv
dv/tb.sv
